/* rtl/lra_pkg.sv */
// lra_pkg: shared types, widths and state codes for the largest-remainder
// apportionment block. No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package lra_pkg;

  // layer count and total limit are fixed by the request and result formats
  localparam int NUM_LAYERS = 4;
  localparam int MAX_TOTAL  = 255;

  localparam int TOTAL_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 8;
  localparam int LAYER_W  = $clog2(NUM_LAYERS);
  localparam int SUM_W    = WEIGHT_W + LAYER_W;
  localparam int PROD_W   = TOTAL_W + WEIGHT_W;
  localparam int STEP_W   = $clog2(TOTAL_W);

  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [LAYER_W-1:0]  layer_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic [7:0]  total_units;
    logic [15:0] weight_layer0;
    logic [15:0] weight_layer1;
    logic [15:0] weight_layer2;
    logic [15:0] weight_layer3;
  } in_item_t;

  typedef struct packed {
    logic [7:0] count_layer0;
    logic [7:0] count_layer1;
    logic [7:0] count_layer2;
    logic [7:0] count_layer3;
    logic       no_weight;
  } out_item_t;

  // shared divider: start loads total*weight, divisor held stable while busy
  typedef struct packed {
    logic    start;
    total_t  total;
    weight_t weight;
    sum_t    divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    total_t quot;
    sum_t   rem;
  } div_rsp_t;

  typedef struct packed {
    logic   start;
    logic   wr_en;
    layer_t wr_idx;
    sum_t   wr_rem;
  } rank_req_t;

  typedef struct packed {
    logic                        done;
    logic [NUM_LAYERS-1:0][LAYER_W-1:0] rank;
  } rank_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_RANK,
    ST_DONE
  } lra_state_e;

endpackage

/* rtl/lra_div.sv */
// lra_div: shared multiply and restoring divide unit, one quotient bit a cycle.
// Depends on lra_pkg.
`timescale 1ns / 1ps

module lra_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lra_pkg::div_req_t req_i,
  output lra_pkg::div_rsp_t rsp_o
);
  import lra_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_W - 1);

  logic [PROD_W-1:0] prod;
  logic [SUM_W:0]    trial;
  logic              ge;
  sum_t              rem_q;
  total_t            lo_q;
  total_t            quot_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  assign prod  = PROD_W'(req_i.total) * PROD_W'(req_i.weight);
  assign trial = {rem_q, lo_q[TOTAL_W-1]};
  assign ge    = trial >= {1'b0, req_i.divisor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient fits the total width since weight never exceeds the sum
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= SUM_W'(prod[PROD_W-1:TOTAL_W]);
      lo_q   <= prod[TOTAL_W-1:0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? SUM_W'(trial - {1'b0, req_i.divisor}) : SUM_W'(trial);
      lo_q   <= {lo_q[TOTAL_W-2:0], 1'b0};
      quot_q <= {quot_q[TOTAL_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* rtl/lra_rank.sv */
// lra_rank: remainder store and pairwise ranking with a single comparator.
// Depends on lra_pkg.
`timescale 1ns / 1ps

module lra_rank (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lra_pkg::rank_req_t req_i,
  output lra_pkg::rank_rsp_t rsp_o
);
  import lra_pkg::*;

  localparam layer_t LAST_I = LAYER_W'(NUM_LAYERS - 2);
  localparam layer_t LAST_J = LAYER_W'(NUM_LAYERS - 1);

  sum_t   mem [NUM_LAYERS];
  sum_t   rd_a_q;
  sum_t   rd_b_q;
  layer_t i_q;
  layer_t j_q;
  layer_t ci_q;
  layer_t cj_q;
  logic   busy_q;
  logic   cmp_vld_q;
  logic   cmp_last_q;
  layer_t rank_q [NUM_LAYERS];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_idx] <= req_i.wr_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rd_a_q <= mem[i_q];
      rd_b_q <= mem[j_q];
      ci_q   <= i_q;
      cj_q   <= j_q;
    end
  end

  // pairs (i, j) with i < j, one per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      cmp_vld_q  <= busy_q;
      cmp_last_q <= busy_q && (i_q == LAST_I);
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        j_q    <= LAYER_W'(1);
      end else if (busy_q) begin
        if (j_q == LAST_J) begin
          if (i_q == LAST_I) begin
            busy_q <= 1'b0;
          end else begin
            i_q <= i_q + LAYER_W'(1);
            j_q <= i_q + LAYER_W'(2);
          end
        end else begin
          j_q <= j_q + LAYER_W'(1);
        end
      end
    end
  end

  // the later layer only beats the earlier one on a strictly larger remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      for (int n = 0; n < NUM_LAYERS; n++) begin
        rank_q[n] <= '0;
      end
    end else if (cmp_vld_q) begin
      if (rd_b_q > rd_a_q) begin
        rank_q[ci_q] <= rank_q[ci_q] + LAYER_W'(1);
      end else begin
        rank_q[cj_q] <= rank_q[cj_q] + LAYER_W'(1);
      end
    end
  end

  always_comb begin
    rsp_o.done = cmp_vld_q && cmp_last_q;
    for (int n = 0; n < NUM_LAYERS; n++) begin
      rsp_o.rank[n] = rank_q[n];
    end
  end

endmodule

/* rtl/largest_remainder_apportion.sv */
// largest_remainder_apportion: top level, sequencer and result register.
// Depends on lra_pkg, lra_div and lra_rank.
`timescale 1ns / 1ps
//
// Splits total_units across four layers in proportion to their weights so
// that, for a nonzero weight sum, the counts add up to the total (largest
// remainder method). Requests arrive on in_valid_i / in_stall_o /
// in_data_i, results leave on out_valid_o / out_stall_i / out_data_o; a
// transfer happens on a clock edge with valid high and stall low. One
// result per request. The sequencer adds the weights one by one, tests the
// sum, passes each layer through the shared multiply/divide unit (one
// quotient bit a cycle), ranks the remainders on the single comparator and
// forms the result. With all weights zero the divide and rank phases are
// skipped and the no_weight flag is set in the result.
// One request is worked on at a time; in_stall_o is low only when idle, so
// a new request is taken only once the last result is loaded for output.
// A finished result sits in the output register while the next request is
// taken in. If the receiver stalls, the result holds, and a further
// finished result waits in the last phase until the register is free.
// Reset clears the sequencer and the output valid; no clearing pass.
//
module largest_remainder_apportion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lra_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lra_pkg::out_item_t out_data_o
);
  import lra_pkg::*;

  localparam layer_t LAST_K = LAYER_W'(NUM_LAYERS - 1);

  lra_state_e state_q, state_d;
  layer_t     k_q;
  total_t     total_q;
  weight_t    w_q [NUM_LAYERS];
  sum_t       sum_q;
  total_t     given_q;
  count_t     cnt_q [NUM_LAYERS];
  count_t     fin_cnt [NUM_LAYERS];
  total_t     leftover;
  total_t     total_in;
  layer_t     div_widx;
  logic       accept;
  logic       out_load;
  logic       out_valid_q;
  out_item_t  out_q;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  rank_req_t  rank_req;
  rank_rsp_t  rank_rsp;

  lra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lra_rank u_rank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rank_req),
    .rsp_o  (rank_rsp)
  );

  assign total_in = (in_data_i.total_units > TOTAL_W'(MAX_TOTAL)) ?
                    TOTAL_W'(MAX_TOTAL) : in_data_i.total_units;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (k_q == LAST_K) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = (sum_q == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done && k_q == LAST_K) state_d = ST_RANK;
      end
      ST_RANK: begin
        if (rank_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    div_widx        = (state_q == ST_DIV) ? k_q + LAYER_W'(1) : '0;
    div_req.start   = ((state_q == ST_CHECK) && (sum_q != '0)) ||
                      ((state_q == ST_DIV) && div_rsp.done && (k_q != LAST_K));
    div_req.total   = total_q;
    div_req.weight  = w_q[div_widx];
    div_req.divisor = sum_q;
    rank_req.wr_en  = (state_q == ST_DIV) && div_rsp.done;
    rank_req.wr_idx = k_q;
    rank_req.wr_rem = div_rsp.rem;
    rank_req.start  = (state_q == ST_DIV) && div_rsp.done && (k_q == LAST_K);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        k_q <= '0;
      end else if (state_q == ST_SUM) begin
        k_q <= (k_q == LAST_K) ? '0 : k_q + LAYER_W'(1);
      end else if (state_q == ST_DIV && div_rsp.done && k_q != LAST_K) begin
        k_q <= k_q + LAYER_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      total_q <= total_in;
      w_q[0]  <= in_data_i.weight_layer0;
      w_q[1]  <= in_data_i.weight_layer1;
      w_q[2]  <= in_data_i.weight_layer2;
      w_q[3]  <= in_data_i.weight_layer3;
      sum_q   <= '0;
      given_q <= '0;
      for (int n = 0; n < NUM_LAYERS; n++) begin
        cnt_q[n] <= '0;
      end
    end else if (state_q == ST_SUM) begin
      sum_q <= sum_q + SUM_W'(w_q[k_q]);
    end else if (state_q == ST_DIV && div_rsp.done) begin
      cnt_q[k_q] <= COUNT_W'(div_rsp.quot);
      given_q    <= given_q + div_rsp.quot;
    end
  end

  // leftover units go to the layers ranked highest by remainder
  always_comb begin
    leftover = total_q - given_q;
    for (int n = 0; n < NUM_LAYERS; n++) begin
      fin_cnt[n] = cnt_q[n] + COUNT_W'((sum_q != '0) &&
                   (TOTAL_W'(rank_rsp.rank[n]) < leftover));
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.count_layer0 <= fin_cnt[0];
      out_q.count_layer1 <= fin_cnt[1];
      out_q.count_layer2 <= fin_cnt[2];
      out_q.count_layer3 <= fin_cnt[3];
      out_q.no_weight    <= (sum_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_rem_below_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_rsp.done) |-> (div_rsp.rem < sum_q))
    else $error("divider remainder not below weight sum");

  a_leftover_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sum_q != '0) |->
      (given_q <= total_q) && (leftover < TOTAL_W'(NUM_LAYERS)))
    else $error("too many units left after floors");

  a_counts_add_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sum_q != '0) |->
      ((TOTAL_W'(fin_cnt[0]) + TOTAL_W'(fin_cnt[1]) + TOTAL_W'(fin_cnt[2]) +
        TOTAL_W'(fin_cnt[3])) == total_q))
    else $error("counts do not add up to total");

  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.no_weight) |->
      (out_data_o.count_layer0 == '0) && (out_data_o.count_layer1 == '0) &&
      (out_data_o.count_layer2 == '0) && (out_data_o.count_layer3 == '0))
    else $error("nonzero count with all weights zero");

endmodule
